// ===== rtl/trld_pkg.sv =====
// Shared types and constants for the text run-length decoder.
`default_nettype none

package trld_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] STATUS_RUN = 2'd0;
    localparam logic [1:0] STATUS_OK  = 2'd1;
    localparam logic [1:0] STATUS_ERR = 2'd2;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_DEL   = 8'h7F;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_DASH  = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    typedef struct packed {
        logic       end_mark;
        logic [7:0] data_byte;
        logic       is_blank;
        logic       is_lf;
        logic       is_ctrl;
        logic       is_digit;
        logic       is_space;
        logic       is_sign;
        logic       is_dash;
    } item_t;

endpackage

`default_nettype wire

// ===== rtl/text_run_length_decoder.sv =====
// Top level of the text run-length decoder: front, queue and parser.
// Throughput: one byte transaction per cycle while the output is not stalled.
// A byte's transaction writes it into the queue; the parser then takes it and registers
// its result, offered on m_tvalid. The four-entry queue absorbs output stalls.
// Reset (aresetn low, synchronous) empties the queue and the output register and
// returns the parser to the run boundary with a zero count and clear flags.
`default_nettype none

module text_run_length_decoder #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tuser,   // [0] end_mark
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [7:0] run_symbol, [23:8] run_length, [25:24] status
    output logic             m_tlast    // last
);
    import trld_pkg::*;

    item_t push_item;
    item_t pop_item;
    logic  push;
    logic  queue_full;
    logic  queue_empty;
    logic  back_ready;

    trld_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .queue_full (queue_full),
        .push       (push),
        .push_item  (push_item)
    );

    trld_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (back_ready),
        .pop_item  (pop_item),
        .empty     (queue_empty)
    );

    trld_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (!queue_empty),
        .in_item  (pop_item),
        .in_ready (back_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

// ===== rtl/trld_front.sv =====
// Input side: accepts stream transactions and classifies each byte.
`default_nettype none

module trld_front (
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [7:0]    s_tdata,   // [7:0] data_byte
    input  wire logic          s_tuser,   // [0] end_mark
    input  wire logic          queue_full,
    output logic               push,
    output trld_pkg::item_t    push_item
);
    import trld_pkg::*;

    logic [7:0] b;

    assign b        = s_tdata;
    assign s_tready = !queue_full;
    assign push     = s_tvalid && !queue_full;

    always_comb begin
        push_item.end_mark  = s_tuser;
        push_item.data_byte = b;
        push_item.is_blank  = (b == CHAR_SPACE) || (b >= CHAR_TAB && b <= CHAR_CR);
        push_item.is_lf     = (b == CHAR_LF);
        push_item.is_ctrl   = (b < CHAR_SPACE) || (b == CHAR_DEL);
        push_item.is_digit  = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
        push_item.is_space  = (b == CHAR_SPACE);
        push_item.is_sign   = (b == CHAR_PLUS) || (b == CHAR_DASH);
        push_item.is_dash   = (b == CHAR_DASH);
    end

endmodule

`default_nettype wire

// ===== rtl/trld_queue.sv =====
// Short queue of classified bytes between the front and the parser.
`default_nettype none

module trld_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  trld_pkg::item_t      push_item,
    output logic                 full,
    input  wire logic            pop,
    output trld_pkg::item_t      pop_item,
    output logic                 empty
);
    import trld_pkg::*;

    item_t                 mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0]   count_reg, count_next;
    logic                  do_push, do_pop;

    assign full     = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_item = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? QUEUE_AW'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? QUEUE_AW'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = QUEUE_CW'(count_reg + 1'b1);
        end else if (do_pop && !do_push) begin
            count_next = QUEUE_CW'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/trld_back.sv =====
// Parser: steps the run grammar on each classified byte and registers results.
`default_nettype none

module trld_back #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    input  trld_pkg::item_t    in_item,
    output logic               in_ready,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [31:0]        m_tdata,   // [7:0] run_symbol, [23:8] run_length, [25:24] status
    output logic               m_tlast    // last
);
    import trld_pkg::*;

    localparam int WW = COUNT_WIDTH + 4;

    localparam logic [2:0] PH_BOUNDARY = 3'd0;
    localparam logic [2:0] PH_BLANKS   = 3'd1;
    localparam logic [2:0] PH_SIGNED   = 3'd2;
    localparam logic [2:0] PH_DIGITS   = 3'd3;
    localparam logic [2:0] PH_SYMBOL   = 3'd4;
    localparam logic [2:0] PH_ESCAPED  = 3'd5;

    logic [2:0]             phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0] acc_reg, acc_next;
    logic                   neg_reg, neg_next;
    logic                   err_reg, err_next;
    logic                   fin_reg, fin_next;

    logic                   out_valid_reg, out_valid_next;
    logic [7:0]             out_sym_reg, out_sym_next;
    logic [15:0]            out_len_reg, out_len_next;
    logic [1:0]             out_status_reg, out_status_next;
    logic                   out_last_reg, out_last_next;

    logic                   load;
    logic                   emit;
    logic                   start_count;
    logic                   add_digit;
    logic                   finish_run;
    logic [WW-1:0]          scaled;
    logic                   digit_ovf;

    assign in_ready = !out_valid_reg || m_tready;
    assign load     = in_valid && in_ready;

    assign scaled = WW'({acc_reg, 3'b000}) + WW'({acc_reg, 1'b0})
                  + WW'(in_item.data_byte[3:0]);
    assign digit_ovf = |scaled[WW-1:COUNT_WIDTH];

    always_comb begin
        phase_next      = phase_reg;
        acc_next        = acc_reg;
        neg_next        = neg_reg;
        err_next        = err_reg;
        fin_next        = fin_reg;
        emit            = 1'b0;
        start_count     = 1'b0;
        add_digit       = 1'b0;
        finish_run      = 1'b0;
        out_sym_next    = out_sym_reg;
        out_len_next    = out_len_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;

        if (in_item.end_mark) begin
            emit            = 1'b1;
            out_sym_next    = '0;
            out_len_next    = '0;
            out_last_next   = 1'b1;
            out_status_next = (err_reg || (!fin_reg && phase_reg != PH_BOUNDARY))
                              ? STATUS_ERR : STATUS_OK;
            phase_next      = PH_BOUNDARY;
            acc_next        = '0;
            neg_next        = 1'b0;
            err_next        = 1'b0;
            fin_next        = 1'b0;
        end else if (!err_reg && !fin_reg) begin
            unique case (phase_reg)
                PH_BOUNDARY: begin
                    if (in_item.is_ctrl) begin
                        fin_next = 1'b1;
                    end else if (in_item.is_space) begin
                        phase_next = PH_BLANKS;
                    end else begin
                        start_count = 1'b1;
                    end
                end
                PH_BLANKS: begin
                    if (in_item.is_lf) begin
                        err_next = 1'b1;
                    end else if (!in_item.is_blank) begin
                        start_count = 1'b1;
                    end
                end
                PH_SIGNED: begin
                    if (in_item.is_digit) begin
                        add_digit = 1'b1;
                    end else begin
                        err_next = 1'b1;
                    end
                end
                PH_DIGITS, PH_SYMBOL: begin
                    if (phase_reg == PH_DIGITS && in_item.is_digit) begin
                        add_digit = 1'b1;
                    end else if (in_item.is_lf) begin
                        err_next = 1'b1;
                    end else if (in_item.is_blank) begin
                        phase_next = PH_SYMBOL;
                    end else if (in_item.is_dash) begin
                        phase_next = PH_ESCAPED;
                    end else begin
                        finish_run = 1'b1;
                    end
                end
                PH_ESCAPED: begin
                    if (in_item.is_lf) begin
                        err_next = 1'b1;
                    end else if (!in_item.is_blank) begin
                        finish_run = 1'b1;
                    end
                end
                default: begin
                    err_next = 1'b1;
                end
            endcase

            if (start_count) begin
                if (in_item.is_sign) begin
                    neg_next   = in_item.is_dash;
                    phase_next = PH_SIGNED;
                end else if (in_item.is_digit) begin
                    add_digit = 1'b1;
                end else begin
                    err_next = 1'b1;
                end
            end

            if (add_digit) begin
                if (digit_ovf) begin
                    err_next = 1'b1;
                end else begin
                    acc_next   = scaled[COUNT_WIDTH-1:0];
                    phase_next = PH_DIGITS;
                end
            end

            if (finish_run) begin
                if (!neg_reg && acc_reg != '0) begin
                    emit            = 1'b1;
                    out_sym_next    = in_item.data_byte;
                    out_len_next    = 16'(acc_reg);
                    out_status_next = STATUS_RUN;
                    out_last_next   = 1'b0;
                end
                acc_next   = '0;
                neg_next   = 1'b0;
                phase_next = PH_BOUNDARY;
            end
        end

        out_valid_next = (out_valid_reg && !m_tready) || (load && emit);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_BOUNDARY;
            acc_reg       <= '0;
            neg_reg       <= 1'b0;
            err_reg       <= 1'b0;
            fin_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (load) begin
                phase_reg <= phase_next;
                acc_reg   <= acc_next;
                neg_reg   <= neg_next;
                err_reg   <= err_next;
                fin_reg   <= fin_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load && emit) begin
            out_sym_reg    <= out_sym_next;
            out_len_reg    <= out_len_next;
            out_status_reg <= out_status_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b000000, out_status_reg, out_len_reg, out_sym_reg};
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire
